@@ hdl/qph_pkg.sv @@
// ----------------------------------------------------------------------------
// qph_pkg: shared types and codes of the quadratic probe hash set
// Status and operation codes, register indexes and the command record
// that travels from the front to the back.
// ----------------------------------------------------------------------------
package qph_pkg;

	localparam int HASH_W = 32;
	localparam int BC_W   = 11;
	localparam int HC_W   = 15;
	localparam int STAT_W = 3;
	// covers key lengths up to 511 bytes
	localparam int LEN_W  = 9;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_ROOM   = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd4;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_FIND = 1'b1;

	localparam logic REG_BUCKET_COUNT  = 1'b0;
	localparam logic REG_HEAP_CAPACITY = 1'b1;

	localparam logic [BC_W-1:0] BC_RESET = 11'd1024;
	localparam logic [HC_W-1:0] HC_RESET = 15'd16384;

	typedef struct packed {
		logic              op;
		logic [HASH_W-1:0] hash;
		logic [LEN_W-1:0]  len;
		logic              over;
		logic              bank;
	} cmd_t;

	typedef struct packed {
		logic init_done;
		logic done;
	} ctl_t;

endpackage

@@ hdl/qph_if.sv @@
// ----------------------------------------------------------------------------
// qph_if: request and result channels
// Valid/ready channels carrying one key byte request and one status result.
// ----------------------------------------------------------------------------
interface qph_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] hash_value;
	logic [7:0]  key_byte;
	logic        last_byte;

	modport source (output valid, output operation, output hash_value,
		output key_byte, output last_byte, input ready);
	modport sink (input valid, input operation, input hash_value,
		input key_byte, input last_byte, output ready);
endinterface

interface qph_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;

	modport source (output valid, output status, input ready);
	modport sink (input valid, input status, output ready);
endinterface

@@ hdl/qph_queue.sv @@
// ----------------------------------------------------------------------------
// qph_queue: two-entry command queue
// Decouples key gathering from the probe engine.
// ----------------------------------------------------------------------------
module qph_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qph_pkg::cmd_t push_cmd,
	input  logic          pop,
	output qph_pkg::cmd_t head,
	output logic          empty
);

	qph_pkg::cmd_t slot_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign head  = slot_q[rp_q];
	assign empty = (cnt_q == 2'd0);

endmodule

@@ hdl/qph_front.sv @@
// ----------------------------------------------------------------------------
// qph_front: key gathering
// Takes key bytes into one of two key buffer banks and queues a command on
// the last byte. Holds off while both banks are owned by pending commands.
// ----------------------------------------------------------------------------
module qph_front #(
	parameter int MAX_KEY = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	qph_in_if.sink                 key_in,
	input  qph_pkg::ctl_t          back_ctl,
	output logic                   push,
	output qph_pkg::cmd_t          push_cmd,
	output logic                   kb_we,
	output logic [$clog2((MAX_KEY > 1) ? MAX_KEY : 2):0] kb_waddr,
	output logic [7:0]             kb_wdata
);

	localparam int KAW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
	localparam int KLW = $clog2(MAX_KEY + 1);

	logic [KLW-1:0] klen_q;
	logic           over_q;
	logic           bank_q;
	logic [1:0]     outst_q;
	logic           acc;
	logic           has_room;
	logic [KLW-1:0] len_now;

	assign key_in.ready = back_ctl.init_done && (outst_q < 2'd2);
	assign acc          = key_in.valid && key_in.ready;
	assign has_room     = klen_q < KLW'(MAX_KEY);
	assign len_now      = has_room ? klen_q + KLW'(1) : klen_q;

	assign kb_we    = acc && has_room;
	assign kb_waddr = {bank_q, klen_q[KAW-1:0]};
	assign kb_wdata = key_in.key_byte;

	assign push          = acc && key_in.last_byte;
	assign push_cmd.op   = key_in.operation;
	assign push_cmd.hash = key_in.hash_value;
	assign push_cmd.len  = qph_pkg::LEN_W'(len_now);
	assign push_cmd.over = over_q || !has_room;
	assign push_cmd.bank = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q  <= '0;
			over_q  <= 1'b0;
			bank_q  <= 1'b0;
			outst_q <= 2'd0;
		end else begin
			if (acc) begin
				if (key_in.last_byte) begin
					klen_q <= '0;
					over_q <= 1'b0;
					bank_q <= ~bank_q;
				end else begin
					klen_q <= len_now;
					if (!has_room) over_q <= 1'b1;
				end
			end
			outst_q <= outst_q + 2'(push) - 2'(back_ctl.done);
		end
	end

endmodule

@@ hdl/qph_back.sv @@
// ----------------------------------------------------------------------------
// qph_back: probe engine
// Runs add and find commands: serial hash reduction, triangular probe walk
// over the bucket memory, byte compare or copy against the element heap.
// ----------------------------------------------------------------------------
module qph_back #(
	parameter int BUCKETS    = 1024,
	parameter int HEAP_BYTES = 16384,
	parameter int MAX_KEY    = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [qph_pkg::BC_W-1:0]     bucket_count,
	input  logic [qph_pkg::HC_W-1:0]     heap_capacity,
	input  qph_pkg::cmd_t                head,
	input  logic                         empty,
	output logic                         pop,
	input  logic                         kb_we,
	input  logic [$clog2((MAX_KEY > 1) ? MAX_KEY : 2):0] kb_waddr,
	input  logic [7:0]                   kb_wdata,
	output qph_pkg::ctl_t                back_ctl,
	qph_out_if.source                    result_out
);

	localparam int KAW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
	localparam int KLW = $clog2(MAX_KEY + 1);
	localparam int BAW = $clog2(BUCKETS);
	localparam int NW  = $clog2(BUCKETS + 1);
	localparam int HAW = $clog2(HEAP_BYTES);
	localparam int HFW = $clog2(HEAP_BYTES + 1);
	localparam int PSW = $clog2(HEAP_BYTES + MAX_KEY + 1);

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_START   = 4'd2;
	localparam logic [3:0] S_MOD     = 4'd3;
	localparam logic [3:0] S_PROBE   = 4'd4;
	localparam logic [3:0] S_BKT     = 4'd5;
	localparam logic [3:0] S_ADV     = 4'd6;
	localparam logic [3:0] S_FIX     = 4'd7;
	localparam logic [3:0] S_CMP_RD  = 4'd8;
	localparam logic [3:0] S_CMP_CHK = 4'd9;
	localparam logic [3:0] S_CP_RD   = 4'd10;
	localparam logic [3:0] S_CP_WR   = 4'd11;
	localparam logic [3:0] S_DONE    = 4'd12;

	logic [3:0]                  state_q;
	logic                        init_q;
	logic [BAW-1:0]              clr_q;
	logic                        op_q;
	logic [31:0]                 hash_q;
	logic [KLW-1:0]              len_q;
	logic                        over_q;
	logic                        bank_q;
	logic [NW-1:0]               n_q;
	logic [5:0]                  cnt_q;
	logic [NW-1:0]               remh_q;
	logic [NW-1:0]               remw_q;
	logic [NW-1:0]               idx_q;
	logic [NW-1:0]               p_q;
	logic [31:0]                 sum_q;
	logic                        carry_q;
	logic [HAW-1:0]              base_q;
	logic [KLW-1:0]              k_q;
	logic [HFW-1:0]              fill_q;
	logic [qph_pkg::STAT_W-1:0]  stat_q;
	logic                        out_valid_q;
	logic [qph_pkg::STAT_W-1:0]  out_status_q;

	logic [HAW-1:0] bkt_mem [BUCKETS];
	logic [7:0]     heap_mem [HEAP_BYTES];
	logic [7:0]     key_mem [2 << KAW];
	logic [HAW-1:0] bkt_rd_s1;
	logic [7:0]     heap_rd_s1;
	logic [7:0]     key_rd_s1;
	logic           pos_ok_s1;

	logic [NW-1:0]  n_live;
	logic [HFW-1:0] cap_live;
	logic           room_ok;
	logic [32:0]    div_h;
	logic [NW-1:0]  remh_nx;
	logic [NW-1:0]  remw_nx;
	logic [NW-1:0]  pn;
	logic [32:0]    sum_nx;
	logic [NW-1:0]  idx_adv;
	logic [NW-1:0]  idx_fix;
	logic [PSW-1:0] pos;
	logic [PSW-1:0] wpos;
	logic           load_out;
	logic           bkt_we;
	logic [BAW-1:0] bkt_waddr;
	logic [HAW-1:0] bkt_wdata;

	function automatic logic [NW-1:0] rem_step(logic [NW-1:0] rem, logic b,
		logic [NW-1:0] n);
		logic [NW:0] sh;
		sh = {rem, b};
		if (sh >= {1'b0, n}) sh = sh - {1'b0, n};
		return sh[NW-1:0];
	endfunction

	// clamp the configured sizes to what the memories hold
	always_comb begin
		logic [31:0] bc;
		logic [31:0] hc;
		logic [31:0] room;
		bc = 32'(bucket_count);
		hc = 32'(heap_capacity);
		if (bc == 32'd0) n_live = NW'(1);
		else if (bc > 32'(BUCKETS)) n_live = NW'(BUCKETS);
		else n_live = NW'(bc);
		if (hc == 32'd0) cap_live = HFW'(1);
		else if (hc > 32'(HEAP_BYTES)) cap_live = HFW'(HEAP_BYTES);
		else cap_live = HFW'(hc);
		room = (cap_live > fill_q) ? 32'(cap_live) - 32'(fill_q) : 32'd0;
		room_ok = room > 32'(len_q);
	end

	assign div_h   = {1'b0, hash_q};
	assign remh_nx = rem_step(remh_q, div_h[cnt_q], n_q);
	assign remw_nx = rem_step(remw_q, cnt_q == 6'd32, n_q);

	assign pn     = p_q + NW'(1);
	assign sum_nx = {1'b0, sum_q} + 33'(pn);

	always_comb begin
		logic [NW:0] t;
		t = {1'b0, idx_q} + {1'b0, pn};
		if (t >= {1'b0, n_q}) t = t - {1'b0, n_q};
		idx_adv = t[NW-1:0];
		// the 32-bit sum wrapped: take 2^32 mod n back out
		if (idx_q >= remw_q) t = {1'b0, idx_q} - {1'b0, remw_q};
		else t = {1'b0, idx_q} + {1'b0, n_q} - {1'b0, remw_q};
		idx_fix = t[NW-1:0];
	end

	assign pos  = PSW'(base_q) + PSW'(k_q);
	assign wpos = PSW'(fill_q) + PSW'(k_q);

	assign load_out = (state_q == S_DONE) && (!out_valid_q || result_out.ready);
	assign pop      = (state_q == S_IDLE) && !empty;

	always_comb begin
		bkt_we    = 1'b0;
		bkt_waddr = clr_q;
		bkt_wdata = '0;
		if (state_q == S_CLR) begin
			bkt_we = 1'b1;
		end else if (state_q == S_BKT && op_q == qph_pkg::OP_ADD && bkt_rd_s1 == '0) begin
			bkt_we    = 1'b1;
			bkt_waddr = idx_q[BAW-1:0];
			bkt_wdata = fill_q[HAW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
		bkt_rd_s1 <= bkt_mem[idx_q[BAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CP_WR) heap_mem[wpos[HAW-1:0]] <= key_rd_s1;
		heap_rd_s1 <= heap_mem[pos[HAW-1:0]];
		// bytes past the fill were never written and read as zero
		pos_ok_s1  <= pos < PSW'(fill_q);
	end

	always_ff @(posedge clk) begin
		if (kb_we) key_mem[kb_waddr] <= kb_wdata;
		key_rd_s1 <= key_mem[{bank_q, k_q[KAW-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= head.op;
			hash_q <= head.hash;
			len_q  <= KLW'(head.len);
			over_q <= head.over;
			bank_q <= head.bank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			init_q       <= 1'b0;
			clr_q        <= '0;
			fill_q       <= HFW'(1);
			out_valid_q  <= 1'b0;
			out_status_q <= qph_pkg::ST_OK;
			stat_q       <= qph_pkg::ST_OK;
			n_q          <= '0;
			cnt_q        <= '0;
			remh_q       <= '0;
			remw_q       <= '0;
			idx_q        <= '0;
			p_q          <= '0;
			sum_q        <= '0;
			carry_q      <= 1'b0;
			base_q       <= '0;
			k_q          <= '0;
		end else begin
			if (load_out) begin
				out_valid_q  <= 1'b1;
				out_status_q <= stat_q;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + BAW'(1);
					if (clr_q == BAW'(BUCKETS - 1)) begin
						init_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!empty) state_q <= S_START;
				end
				S_START: begin
					n_q    <= n_live;
					cnt_q  <= 6'd32;
					remh_q <= '0;
					remw_q <= '0;
					if (over_q) begin
						stat_q  <= qph_pkg::ST_TOO_LONG;
						state_q <= S_DONE;
					end else if (op_q == qph_pkg::OP_ADD && !room_ok) begin
						stat_q  <= qph_pkg::ST_NO_ROOM;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					// one remainder bit a cycle for hash mod n and 2^32 mod n
					remh_q <= remh_nx;
					remw_q <= remw_nx;
					cnt_q  <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						idx_q   <= remh_nx;
						p_q     <= '0;
						sum_q   <= hash_q;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= S_BKT;
				end
				S_BKT: begin
					k_q <= '0;
					if (bkt_rd_s1 == '0) begin
						if (op_q == qph_pkg::OP_ADD) begin
							state_q <= S_CP_RD;
						end else begin
							stat_q  <= qph_pkg::ST_NOT_FOUND;
							state_q <= S_DONE;
						end
					end else if (op_q == qph_pkg::OP_FIND) begin
						base_q  <= bkt_rd_s1;
						state_q <= S_CMP_RD;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (pn == n_q) begin
						stat_q  <= (op_q == qph_pkg::OP_ADD) ? qph_pkg::ST_FULL
							: qph_pkg::ST_NOT_FOUND;
						state_q <= S_DONE;
					end else begin
						p_q     <= pn;
						sum_q   <= sum_nx[31:0];
						carry_q <= sum_nx[32];
						idx_q   <= idx_adv;
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (carry_q) idx_q <= idx_fix;
					state_q <= S_PROBE;
				end
				S_CMP_RD: begin
					if (k_q == len_q) begin
						stat_q  <= qph_pkg::ST_OK;
						state_q <= S_DONE;
					end else begin
						state_q <= S_CMP_CHK;
					end
				end
				S_CMP_CHK: begin
					if ((pos_ok_s1 ? heap_rd_s1 : 8'd0) != key_rd_s1) begin
						state_q <= S_ADV;
					end else begin
						k_q     <= k_q + KLW'(1);
						state_q <= S_CMP_RD;
					end
				end
				S_CP_RD: begin
					if (k_q == len_q) begin
						fill_q  <= fill_q + HFW'(len_q);
						stat_q  <= qph_pkg::ST_OK;
						state_q <= S_DONE;
					end else begin
						state_q <= S_CP_WR;
					end
				end
				S_CP_WR: begin
					k_q     <= k_q + KLW'(1);
					state_q <= S_CP_RD;
				end
				S_DONE: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign back_ctl.init_done = init_q;
	assign back_ctl.done      = load_out;
	assign result_out.valid   = out_valid_q;
	assign result_out.status  = out_status_q;

endmodule

@@ hdl/quadratic_probe_hash_set.sv @@
// ----------------------------------------------------------------------------
// quadratic_probe_hash_set: open-addressing byte-string set
// Top level: configuration registers, key front, command queue, probe engine.
// ----------------------------------------------------------------------------
// Key bytes are taken one per cycle while key_in.ready is high; a byte
// without the last mark gives no result. The last byte queues the
// operation, which opens with a 33-step serial reduction of the hash modulo
// the bucket count, then probes buckets and compares (find) or copies into
// the heap (add) the key bytes one by one. Two keys may be pending, so
// gathering of the next key overlaps the current operation. After reset the
// bucket memory is swept to empty, during which no key byte is taken;
// register writes are taken at any time.
module quadratic_probe_hash_set #(
	parameter int BUCKETS    = 1024,
	parameter int HEAP_BYTES = 16384,
	parameter int MAX_KEY    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	qph_in_if.sink      key_in,
	qph_out_if.source   result_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int KAW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

	logic [qph_pkg::BC_W-1:0] bc_q;
	logic [qph_pkg::HC_W-1:0] hc_q;
	logic                     cfg_wr;
	qph_pkg::ctl_t            back_ctl;
	qph_pkg::cmd_t            push_cmd;
	qph_pkg::cmd_t            head;
	logic                     push;
	logic                     pop;
	logic                     empty;
	logic                     kb_we;
	logic [KAW:0]             kb_waddr;
	logic [7:0]               kb_wdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= qph_pkg::BC_RESET;
			hc_q <= qph_pkg::HC_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				qph_pkg::REG_BUCKET_COUNT:  bc_q <= pwdata[qph_pkg::BC_W-1:0];
				qph_pkg::REG_HEAP_CAPACITY: hc_q <= pwdata[qph_pkg::HC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			qph_pkg::REG_BUCKET_COUNT:  prdata = 32'(bc_q);
			qph_pkg::REG_HEAP_CAPACITY: prdata = 32'(hc_q);
			default:                    prdata = '0;
		endcase
	end

	qph_front #(.MAX_KEY(MAX_KEY)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_in   (key_in),
		.back_ctl (back_ctl),
		.push     (push),
		.push_cmd (push_cmd),
		.kb_we    (kb_we),
		.kb_waddr (kb_waddr),
		.kb_wdata (kb_wdata)
	);

	qph_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	qph_back #(
		.BUCKETS    (BUCKETS),
		.HEAP_BYTES (HEAP_BYTES),
		.MAX_KEY    (MAX_KEY)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.bucket_count  (bc_q),
		.heap_capacity (hc_q),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.kb_we         (kb_we),
		.kb_waddr      (kb_waddr),
		.kb_wdata      (kb_wdata),
		.back_ctl      (back_ctl),
		.result_out    (result_out)
	);

endmodule

@@ hdl/qph_checker.sv @@
// ----------------------------------------------------------------------------
// qph_checker: port-level checks of the hash set
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module qph_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped or changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == qph_pkg::ST_OK || status == qph_pkg::ST_NO_ROOM
			|| status == qph_pkg::ST_FULL || status == qph_pkg::ST_NOT_FOUND
			|| status == qph_pkg::ST_TOO_LONG)
		else $error("undefined status code");

	// no request taken and no result offered during reset
	assert property (@(posedge clk) !arst_n |-> !in_ready && !out_valid)
		else $error("channel active during reset");

endmodule

bind quadratic_probe_hash_set qph_checker u_qph_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (key_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.status    (result_out.status)
);
